@@ src/tile_residency_manager_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the tile residency manager
// Implication checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TILE_RESIDENCY_MANAGER_CORE_ASSERT_SVH
`define TILE_RESIDENCY_MANAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TRM_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication
`define TRM_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define TRM_ASSERT_IMP(label, clk, rst_n, pre, post, msg)
`define TRM_ASSERT_NXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/trm_pkg.sv @@
// ---------------------------------------------------------------------------
// trm_pkg
// Beat types and register codes of the tile residency manager.
// ---------------------------------------------------------------------------
package trm_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CAPACITY    = 1024;
	localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

	localparam logic [0:0] REG_DRAW_RADIUS = 1'b0;
	localparam logic [3:0] DRAW_RADIUS_RST = 4'd8;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
	} tick_t;

	typedef struct packed {
		logic                          evict_valid;
		logic signed [COORD_WIDTH-1:0] evict_x;
		logic signed [COORD_WIDTH-1:0] evict_y;
		logic                          load_valid;
		logic signed [COORD_WIDTH-1:0] load_x;
		logic signed [COORD_WIDTH-1:0] load_y;
		logic        [COUNT_WIDTH-1:0] resident_count;
		logic                          table_full;
	} result_t;

endpackage

@@ src/tile_residency_manager_core.sv @@
// ---------------------------------------------------------------------------
// tile_residency_manager_core
// Keeps the resident tile table around a viewer: per tick evicts the
// farthest tile outside the keep bound and admits the nearest missing one.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | beat
//  tick    | in        | tick_valid / tick_stall   | trm_pkg::tick_t
//  res     | out       | res_valid / res_stall     | trm_pkg::result_t
//  cfg     | in        | APB psel/penable/pready   | draw_radius at 0x0
//
//  One tick runs a map clear, one pass over the slot memory read port and
//  one pass over the disc offsets of radius r (r = saturated draw_radius)
//  through the near map port. After reset a clearing pass runs over the
//  slot memory.
//  A finished result waits in an output register; a new tick is taken
//  meanwhile, and the result is only blocked at the end of the next tick.
// ---------------------------------------------------------------------------
`include "tile_residency_manager_core_assert.svh"

module tile_residency_manager_core #(
	parameter int MAX_RADIUS  = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  trm_pkg::tick_t    tick,
	output logic              res_valid,
	input  logic              res_stall,
	output trm_pkg::result_t  res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CAPACITY = trm_pkg::CAPACITY;
	localparam int CW   = trm_pkg::COORD_WIDTH;
	localparam int AW   = $clog2(CAPACITY);
	localparam int CNTW = trm_pkg::COUNT_WIDTH;
	localparam int MAPD = 2 * MAX_RADIUS + 1;
	localparam int MW   = $clog2(MAPD);
	localparam int RW   = $clog2(MAX_RADIUS + 1);
	localparam int DW   = $clog2(2 * (MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
	localparam int SW   = 2 * CW + 1;
	localparam int EW   = 2 * CW + 1;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_MCLR, ST_SCAN, ST_CAND, ST_EVW, ST_LDW, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0] radius_q;
	logic       cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == trm_pkg::REG_DRAW_RADIUS) ? {28'd0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= trm_pkg::DRAW_RADIUS_RST;
		end else if (cfg_wr && paddr[2] == trm_pkg::REG_DRAW_RADIUS) begin
			radius_q <= pwdata[3:0];
		end
	end

	logic [RW-1:0] r_eff;
	logic [RW:0]   r_p1;
	assign r_eff = (6'(radius_q) > 6'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
	assign r_p1  = {1'b0, r_eff} + 1'b1;

	// memories
	logic [EW-1:0]   slot_mem [CAPACITY];
	logic [MAPD-1:0] map_mem  [MAPD];

	logic            slot_we;
	logic [AW-1:0]   slot_waddr;
	logic [EW-1:0]   slot_wdata;
	logic            slot_re;
	logic [EW-1:0]   slot_rd_s1;

	logic            map_we;
	logic [MW-1:0]   map_waddr;
	logic [MAPD-1:0] map_wdata;
	logic            map_re;
	logic [MW-1:0]   map_raddr;
	logic [MAPD-1:0] map_rd_q;

	// tick registers
	logic [CNTW-1:0] cnt_q;
	logic [MW-1:0]   mrow_q;
	logic [CW-1:0]   cx_q, cy_q;
	logic [DW-1:0]   bound_q;
	logic [CNTW-1:0] used_total_q;

	// slot scan pipeline
	logic            v_s1;
	logic [AW-1:0]   idx_s1;
	logic            v_s2;
	logic [CW-1:0]   dx_s2, dy_s2, col_s2, row_s2;
	logic [AW-1:0]   idx_s2;
	logic            v_s3, mk_s3;
	logic [2*CW-1:0] sqx_s3, sqy_s3;
	logic [CW-1:0]   col_s3, row_s3;
	logic [AW-1:0]   idx_s3;
	logic [MW-1:0]   mrow_s3, mcol_s3;
	logic            wr_vld_q;
	logic [MW-1:0]   wr_row_q;
	logic [MAPD-1:0] wr_word_q;

	logic [SW-1:0]   far_q;
	logic [AW-1:0]   far_slot_q;
	logic [CW-1:0]   far_x_q, far_y_q;
	logic            free_found_q;
	logic [AW-1:0]   free_idx_q;

	// candidate pipeline
	logic [RW-1:0]   ox_q, oy_q;
	logic [1:0]      os_q;
	logic            cand_done_q;
	logic            v_c1;
	logic [MW-1:0]   ccol_c1;
	logic [DW-1:0]   d_c1;
	logic [CW-1:0]   px_c1, py_c1;
	logic [DW-1:0]   best_q;
	logic [CW-1:0]   tx_q, ty_q;

	logic              res_valid_q;
	trm_pkg::result_t  res_q;

	// scan stage combinational
	logic            scan_issue;
	logic            used1;
	logic [CW-1:0]   col1, row1;
	logic [CW-1:0]   magx2, magy2;
	logic            near2;
	logic [MW-1:0]   mrow2, mcol2;
	logic [SW-1:0]   dist3;
	logic [MAPD-1:0] mword3;

	assign scan_issue = (state_q == ST_SCAN) && (cnt_q < CNTW'(CAPACITY));
	assign used1 = slot_rd_s1[EW-1];
	assign col1  = slot_rd_s1[2*CW-1:CW];
	assign row1  = slot_rd_s1[CW-1:0];
	assign magx2 = dx_s2[CW-1] ? (~dx_s2 + 1'b1) : dx_s2;
	assign magy2 = dy_s2[CW-1] ? (~dy_s2 + 1'b1) : dy_s2;
	assign near2 = v_s2 && (magx2 <= CW'(MAX_RADIUS)) && (magy2 <= CW'(MAX_RADIUS));
	assign mrow2 = MW'(dy_s2 + CW'(MAX_RADIUS));
	assign mcol2 = MW'(dx_s2 + CW'(MAX_RADIUS));
	assign dist3 = SW'(sqx_s3) + SW'(sqy_s3);
	assign mword3 = ((wr_vld_q && wr_row_q == mrow_s3) ? wr_word_q : map_rd_q)
		| (MAPD'(1) << mcol_s3);

	// candidate issue combinational
	logic [MW-1:0]   crow, ccol;
	logic            cand_issue;
	assign cand_issue = (state_q == ST_CAND) && !cand_done_q;
	assign crow = os_q[0] ? (MW'(MAX_RADIUS) + MW'(oy_q)) : (MW'(MAX_RADIUS) - MW'(oy_q));
	assign ccol = os_q[1] ? (MW'(MAX_RADIUS) + MW'(ox_q)) : (MW'(MAX_RADIUS) - MW'(ox_q));

	// final decisions
	logic          ev, found, avail;
	logic [AW-1:0] load_slot;
	assign ev        = (far_q != '0);
	assign found     = (best_q != bound_q);
	assign avail     = ev || free_found_q;
	assign load_slot = (ev && (!free_found_q || far_slot_q < free_idx_q)) ? far_slot_q
		: free_idx_q;

	// memory port muxes
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cnt_q[AW-1:0];
		slot_wdata = '0;
		unique case (state_q)
			ST_INIT: slot_we = 1'b1;
			ST_EVW: begin
				slot_we    = ev;
				slot_waddr = far_slot_q;
			end
			ST_LDW: begin
				slot_we    = found && avail;
				slot_waddr = load_slot;
				slot_wdata = {1'b1, tx_q, ty_q};
			end
			default: slot_we = 1'b0;
		endcase
		slot_re = scan_issue;

		map_we    = 1'b0;
		map_waddr = mrow_q;
		map_wdata = '0;
		if (state_q == ST_MCLR) begin
			map_we = 1'b1;
		end else if (mk_s3) begin
			map_we    = 1'b1;
			map_waddr = mrow_s3;
			map_wdata = mword3;
		end
		map_re    = near2 || cand_issue;
		map_raddr = (state_q == ST_CAND) ? crow : mrow2;
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re) slot_rd_s1 <= slot_mem[cnt_q[AW-1:0]];
		if (map_we) map_mem[map_waddr] <= map_wdata;
		if (map_re) map_rd_q <= map_mem[map_raddr];
	end

	// payload pipeline registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		dx_s2  <= col1 - cx_q;
		dy_s2  <= row1 - cy_q;
		col_s2 <= col1;
		row_s2 <= row1;
		idx_s2 <= idx_s1;
		sqx_s3 <= magx2 * magx2;
		sqy_s3 <= magy2 * magy2;
		col_s3 <= col_s2;
		row_s3 <= row_s2;
		idx_s3 <= idx_s2;
		mrow_s3 <= mrow2;
		mcol_s3 <= mcol2;
		wr_row_q  <= mrow_s3;
		wr_word_q <= mword3;
		ccol_c1 <= ccol;
		d_c1    <= DW'(ox_q) * DW'(ox_q) + DW'(oy_q) * DW'(oy_q);
		px_c1   <= os_q[1] ? (cx_q + CW'(ox_q)) : (cx_q - CW'(ox_q));
		py_c1   <= os_q[0] ? (cy_q + CW'(oy_q)) : (cy_q - CW'(oy_q));
	end

	assign tick_stall = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cnt_q        <= '0;
			mrow_q       <= '0;
			used_total_q <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			mk_s3        <= 1'b0;
			wr_vld_q     <= 1'b0;
			v_c1         <= 1'b0;
			cand_done_q  <= 1'b0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			bound_q      <= '0;
			far_q        <= '0;
			far_slot_q   <= '0;
			far_x_q      <= '0;
			far_y_q      <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			ox_q         <= '0;
			oy_q         <= '0;
			os_q         <= '0;
			best_q       <= '0;
			tx_q         <= '0;
			ty_q         <= '0;
		end else begin
			// drop the held beat once taken, unless a new one replaces it
			if (res_valid_q && !res_stall && state_q != ST_DONE) res_valid_q <= 1'b0;
			v_s1     <= scan_issue;
			v_s2     <= v_s1 && used1;
			v_s3     <= v_s2;
			mk_s3    <= near2 && (state_q == ST_SCAN);
			wr_vld_q <= mk_s3;
			v_c1     <= cand_issue;

			// lowest unused slot seen so far
			if (v_s1 && !used1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			// farthest tile at or beyond the bound, first slot on ties
			if (v_s3 && dist3 >= SW'(bound_q) && dist3 > far_q) begin
				far_q      <= dist3;
				far_slot_q <= idx_s3;
				far_x_q    <= col_s3;
				far_y_q    <= row_s3;
			end
			// nearest missing tile, first in scan order
			if (v_c1 && d_c1 < best_q && !map_rd_q[ccol_c1]) begin
				best_q <= d_c1;
				tx_q   <= px_c1;
				ty_q   <= py_c1;
			end

			unique case (state_q)
				ST_INIT: begin
					if (cnt_q == CNTW'(CAPACITY - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (tick_valid) begin
						cx_q         <= CW'($unsigned(tick.center_x));
						cy_q         <= CW'($unsigned(tick.center_y));
						bound_q      <= DW'(r_p1) * DW'(r_p1);
						far_q        <= '0;
						free_found_q <= 1'b0;
						mrow_q       <= '0;
						state_q      <= ST_MCLR;
					end
				end
				ST_MCLR: begin
					if (mrow_q == MW'(MAPD - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						mrow_q <= mrow_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3 && !mk_s3) begin
						ox_q        <= '0;
						oy_q        <= '0;
						os_q        <= '0;
						cand_done_q <= 1'b0;
						best_q      <= bound_q;
						state_q     <= ST_CAND;
					end
				end
				ST_CAND: begin
					if (cand_issue) begin
						// advance sign, then y offset, then x offset
						if (os_q == 2'd3) begin
							os_q <= '0;
							if (oy_q == r_eff) begin
								oy_q <= '0;
								if (ox_q == r_eff) cand_done_q <= 1'b1;
								else ox_q <= ox_q + 1'b1;
							end else begin
								oy_q <= oy_q + 1'b1;
							end
						end else begin
							os_q <= os_q + 1'b1;
						end
					end else if (!v_c1) begin
						state_q <= ST_EVW;
					end
				end
				ST_EVW: state_q <= ST_LDW;
				ST_LDW: begin
					used_total_q <= used_total_q - CNTW'(ev) + CNTW'(found && avail);
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q          <= 1'b1;
						res_q.evict_valid    <= ev;
						res_q.evict_x        <= ev ? far_x_q : '0;
						res_q.evict_y        <= ev ? far_y_q : '0;
						res_q.load_valid     <= found && avail;
						res_q.load_x         <= (found && avail) ? tx_q : '0;
						res_q.load_y         <= (found && avail) ? ty_q : '0;
						res_q.resident_count <= used_total_q;
						res_q.table_full     <= found && !avail;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TRM_ASSERT_NXT(a_tick_starts_work, clk, arst_n, tick_valid && !tick_stall, tick_stall, "tick accepted but block idle")
	`TRM_ASSERT_IMP(a_scan_in_phase, clk, arst_n, v_s3 || mk_s3, state_q == ST_SCAN, "slot pipeline busy outside scan")
	`TRM_ASSERT_IMP(a_load_not_full, clk, arst_n, res_valid_q && res_q.load_valid, !res_q.table_full, "load and table full together")
	`TRM_ASSERT_IMP(a_no_evict_zero, clk, arst_n, res_valid_q && !res_q.evict_valid, res_q.evict_x == 16'd0 && res_q.evict_y == 16'd0, "evict coordinates without eviction")

endmodule

@@ sim/tb_tile_residency_manager_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tile_residency_manager_core
// Drives viewer positions through the tick channel and compares each result
// beat against a behavioral table model; sweeps draw_radius over the APB port.
// ---------------------------------------------------------------------------
module tb_tile_residency_manager_core;

	localparam int SLOTS   = trm_pkg::CAPACITY;
	localparam int RAD_MAX = 15;

	logic              clk;
	logic              arst_n;
	logic              tick_valid;
	logic              tick_stall;
	trm_pkg::tick_t    tick;
	logic              res_valid;
	logic              res_stall;
	trm_pkg::result_t  res;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	tile_residency_manager_core dut (
		.clk(clk), .arst_n(arst_n),
		.tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the tile table
	logic [15:0] tile_col [SLOTS];
	logic [15:0] tile_row [SLOTS];
	bit          tile_used [SLOTS];
	int unsigned tile_total;
	logic [3:0]  radius_reg;

	trm_pkg::result_t expected_q[$];
	int          errors;
	bit          hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint unsigned axis_gap(logic [15:0] a, logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		if (d[15])
			d = -d;
		return (d == 16'h8000) ? 32768 : d;
	endfunction

	function automatic longint unsigned dist2(logic [15:0] ax, logic [15:0] ay,
			logic [15:0] bx, logic [15:0] by);
		longint unsigned dx, dy;
		dx = axis_gap(ax, bx);
		dy = axis_gap(ay, by);
		return dx * dx + dy * dy;
	endfunction

	function automatic bit tile_present(logic [15:0] x, logic [15:0] y);
		for (int i = 0; i < SLOTS; i++)
			if (tile_used[i] && tile_col[i] == x && tile_row[i] == y)
				return 1'b1;
		return 1'b0;
	endfunction

	// one tick of the residency table: evict farthest, admit nearest
	function automatic trm_pkg::result_t advance_table(trm_pkg::tick_t t);
		trm_pkg::result_t r;
		int unsigned rad, far_slot, free_slot;
		longint unsigned bound, far, best, d;
		logic [15:0] cx, cy, px, py, bx, by;
		r = '0;
		cx = t.center_x;
		cy = t.center_y;
		rad = (radius_reg > RAD_MAX) ? RAD_MAX : radius_reg;
		bound = (rad + 1) * (rad + 1);
		far = 0;
		far_slot = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (tile_used[i]) begin
				d = dist2(tile_col[i], tile_row[i], cx, cy);
				if (d >= bound && d > far) begin
					far = d;
					far_slot = i;
				end
			end
		end
		if (far != 0) begin
			r.evict_valid = 1'b1;
			r.evict_x = tile_col[far_slot];
			r.evict_y = tile_row[far_slot];
			tile_used[far_slot] = 1'b0;
			tile_total--;
		end
		best = bound;
		bx = '0;
		by = '0;
		for (longint unsigned x = 0; x * x < best; x++)
			for (longint unsigned y = 0; x * x + y * y < best; y++) begin
				d = x * x + y * y;
				for (int s = 0; s < 4; s++) begin
					px = s[1] ? cx + x[15:0] : cx - x[15:0];
					py = s[0] ? cy + y[15:0] : cy - y[15:0];
					if (d < best && !tile_present(px, py)) begin
						best = d;
						bx = px;
						by = py;
					end
				end
			end
		if (best != bound) begin
			free_slot = SLOTS;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!tile_used[i])
					free_slot = i;
			if (free_slot < SLOTS) begin
				tile_used[free_slot] = 1'b1;
				tile_col[free_slot] = bx;
				tile_row[free_slot] = by;
				tile_total++;
				r.load_valid = 1'b1;
				r.load_x = bx;
				r.load_y = by;
			end else begin
				r.table_full = 1'b1;
			end
		end
		r.resident_count = tile_total[10:0];
		return r;
	endfunction

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {trm_pkg::REG_DRAW_RADIUS, 2'b00})
			radius_reg = data[3:0];
		// read back the register at the same address
		@(posedge clk);
		want = (addr[2] == trm_pkg::REG_DRAW_RADIUS) ? {28'd0, radius_reg} : 32'd0;
		if (prdata !== want) begin
			$display("%0t readback mismatch: expected %h actual %h", $time, want, prdata);
			errors++;
		end
	endtask

	// send one beat; burst/gap shaping is done by the caller
	task automatic send_tick(trm_pkg::tick_t t);
		tick_valid <= 1'b1;
		tick <= t;
		@(posedge clk);
		while (tick_stall)
			@(posedge clk);
		expected_q.push_back(advance_table(t));
	endtask

	int burst_left;
	task automatic send_paced(trm_pkg::tick_t t);
		if (burst_left == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(0, 6))
				@(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		send_tick(t);
	endtask

	task automatic drain_idle();
		tick_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		// leave time for a tick at the largest radius to finish
		repeat (6000)
			@(posedge clk);
	endtask

	// receiver: stall pattern plus one long hold-off
	int stall_mode;
	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else if (hold_off)
			res_stall <= 1'b1;
		else
			case (stall_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 3) == 0);
				default: res_stall <= ($urandom_range(0, 1) == 0);
			endcase
	end

	always @(posedge clk) begin
		trm_pkg::result_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, res);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (res !== e) begin
					$display("%0t mismatch: expected %p actual %p", $time, e, res);
					errors++;
				end
			end
		end
	end

	// directed rows: position, and a typed-in expectation where obvious
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 typed;
		trm_pkg::result_t   want;
	} dir_row_t;

	dir_row_t          rows[$];
	trm_pkg::tick_t    t;
	trm_pkg::result_t  first_want;
	int                pos_x, pos_y;

	initial begin
		errors = 0;
		hold_off = 1'b0;
		stall_mode = 0;
		burst_left = 0;
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < SLOTS; i++)
			tile_used[i] = 1'b0;
		tile_total = 0;
		radius_reg = trm_pkg::DRAW_RADIUS_RST;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset at the default radius the center itself loads first
		first_want = '0;
		first_want.load_valid = 1'b1;
		first_want.resident_count = 11'd1;
		rows.push_back('{16'sd0, 16'sd0, 1'b1, first_want});
		rows.push_back('{16'sd0, 16'sd0, 1'b0, '0});
		rows.push_back('{16'sh7fff, 16'sh7fff, 1'b0, '0});
		rows.push_back('{-16'sd32768, -16'sd32768, 1'b0, '0});
		rows.push_back('{16'sh7fff, -16'sd32768, 1'b0, '0});
		rows.push_back('{-16'sd32768, 16'sh7fff, 1'b0, '0});
		rows.push_back('{16'sh5555, -16'sh5556, 1'b0, '0});
		rows.push_back('{-16'sh5556, 16'sh5555, 1'b0, '0});
		foreach (rows[i]) begin
			t.center_x = rows[i].x;
			t.center_y = rows[i].y;
			if (rows[i].typed) begin
				void'(advance_table(t));
				expected_q.push_back(rows[i].want);
				tick_valid <= 1'b1;
				tick <= t;
				@(posedge clk);
				while (tick_stall)
					@(posedge clk);
			end else begin
				send_tick(t);
			end
		end
		drain_idle();

		// radius 0: one tile at a time, plus a bad-index write that is dropped
		apb_write(3'd4, 32'd9);
		apb_write({trm_pkg::REG_DRAW_RADIUS, 2'b00}, 32'h0);
		for (int i = 0; i < 6; i++) begin
			t.center_x = 16'(i);
			t.center_y = 16'(i);
			send_tick(t);
		end
		drain_idle();

		// largest radius, with upper data bits set: load tiles around one fixed position
		apb_write({trm_pkg::REG_DRAW_RADIUS, 2'b00}, 32'hffff_fff0 | 32'd15);
		stall_mode = 1;
		pos_x = 0;
		pos_y = 0;
		for (int i = 0; i < 8; i++) begin
			t.center_x = 16'(pos_x);
			t.center_y = 16'(pos_y);
			send_paced(t);
		end
		drain_idle();

		// long receiver hold-off while ticks keep coming
		apb_write({trm_pkg::REG_DRAW_RADIUS, 2'b00}, 32'd2);
		fork
			begin
				hold_off = 1'b1;
				repeat (30000)
					@(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) begin
				t.center_x = 16'($urandom);
				t.center_y = 16'($urandom);
				send_tick(t);
			end
		join
		drain_idle();

		// random walk with occasional jumps, radius changed per phase
		for (int ph = 0; ph < 4; ph++) begin
			apb_write({trm_pkg::REG_DRAW_RADIUS, 2'b00},
				ph == 3 ? 32'd15 : $urandom_range(0, 6));
			stall_mode = ph % 3;
			pos_x = $urandom_range(0, 65535);
			pos_y = $urandom_range(0, 65535);
			for (int i = 0; i < 30; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					pos_x = $urandom_range(0, 65535);
					pos_y = $urandom_range(0, 65535);
				end else begin
					pos_x += int'($urandom_range(0, 4)) - 2;
					pos_y += int'($urandom_range(0, 4)) - 2;
				end
				t.center_x = 16'(pos_x);
				t.center_y = 16'(pos_y);
				send_paced(t);
			end
			drain_idle();
		end

		if (errors == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/trm_pkg.sv
src/tile_residency_manager_core.sv
sim/tb_tile_residency_manager_core.sv
